### sv/irct_pkg.sv
// Shared types and constants of the infrared carrier burst transmitter.
package irct_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int DUR_W       = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PTR_W       = $clog2(TABLE_DEPTH + 2);
    localparam int SEQ_LEN_W   = 9;
    localparam int CNT_W       = 8;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEQ_LEN  = 2'd0,
        REG_REPEAT   = 2'd1,
        REG_CAR_HIGH = 2'd2,
        REG_CAR_WRAP = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SEQ_LEN_W-1:0] seq_len;
        logic [CNT_W-1:0]     repeat_count;
        logic [CNT_W-1:0]     carrier_high;
        logic [CNT_W-1:0]     carrier_wrap;
    } cfg_t;

    typedef struct packed {
        logic pin_level;
        logic busy;
        logic finished;
    } result_t;

endpackage

### sv/irct_table_ram.sv
// Duration table memory: one write port, two registered read ports with write forwarding.
module irct_table_ram (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [irct_pkg::ADDR_W-1:0] wr_addr,
    input  logic [irct_pkg::DUR_W-1:0]  wr_data,
    input  logic [irct_pkg::ADDR_W-1:0] rd_addr_a,
    output logic [irct_pkg::DUR_W-1:0]  rd_data_a,
    input  logic [irct_pkg::ADDR_W-1:0] rd_addr_b,
    output logic [irct_pkg::DUR_W-1:0]  rd_data_b
);
    import irct_pkg::*;

    logic [DUR_W-1:0] dur_mem_reg [TABLE_DEPTH];
    logic [DUR_W-1:0] rd_a_reg;
    logic [DUR_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dur_mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_a_reg <= wr_data;
        end else begin
            rd_a_reg <= dur_mem_reg[rd_addr_a];
        end
        if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_b_reg <= wr_data;
        end else begin
            rd_b_reg <= dur_mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### sv/irct_seq.sv
// Playback sequencer: pointer, duration and carrier state around the duration table.
module irct_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  irct_pkg::op_t               operation,
    input  logic [irct_pkg::IDX_W-1:0]  entry_index,
    input  logic [irct_pkg::DUR_W-1:0]  entry_value,
    input  irct_pkg::cfg_t              cfg,
    output irct_pkg::result_t           result
);
    import irct_pkg::*;

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             in_mark_reg, in_mark_next;
    logic [DUR_W-1:0] mark_left_reg, mark_left_next;
    logic [DUR_W-1:0] space_left_reg, space_left_next;
    logic [CNT_W-1:0] cc_reg, cc_next;
    logic [CNT_W-1:0] repeats_reg, repeats_next;
    logic             running_reg, running_next;
    logic             pin_reg, pin_next;
    logic             fin;

    logic [PTR_W-1:0] eff_len;
    logic [CNT_W-1:0] cc_inc;
    logic [DUR_W-1:0] rd_ptr_data;
    logic [DUR_W-1:0] rd_zero_data;
    logic [DUR_W-1:0] load_ptr;
    logic [DUR_W-1:0] load_zero;
    logic             wr_en;

    assign eff_len   = (32'(cfg.seq_len) > TABLE_DEPTH) ? PTR_W'(TABLE_DEPTH)
                                                        : PTR_W'(cfg.seq_len);
    assign load_ptr  = (ptr_reg < eff_len) ? rd_ptr_data : '0;
    assign load_zero = (eff_len != '0) ? rd_zero_data : '0;
    assign cc_inc    = cc_reg + CNT_W'(1);
    assign wr_en     = accept && (operation == OP_WRITE) && (32'(entry_index) < TABLE_DEPTH);

    irct_table_ram u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (ADDR_W'(entry_index)),
        .wr_data   (entry_value),
        .rd_addr_a (ptr_next[ADDR_W-1:0]),
        .rd_data_a (rd_ptr_data),
        .rd_addr_b ('0),
        .rd_data_b (rd_zero_data)
    );

    always_comb begin
        ptr_next        = ptr_reg;
        in_mark_next    = in_mark_reg;
        mark_left_next  = mark_left_reg;
        space_left_next = space_left_reg;
        cc_next         = cc_reg;
        repeats_next    = repeats_reg;
        running_next    = running_reg;
        pin_next        = pin_reg;
        fin             = 1'b0;
        if (accept) begin
            case (operation)
                OP_START: begin
                    repeats_next    = CNT_W'(1);
                    in_mark_next    = 1'b1;
                    mark_left_next  = load_zero;
                    space_left_next = '0;
                    ptr_next        = PTR_W'(1);
                    cc_next         = '0;
                    pin_next        = 1'b0;
                    running_next    = 1'b1;
                end
                OP_TICK: begin
                    if (running_reg) begin
                        if ((eff_len != '0) && (ptr_reg <= eff_len)) begin
                            if (in_mark_reg) begin
                                if (mark_left_reg != '0) begin
                                    mark_left_next = mark_left_reg - DUR_W'(1);
                                    cc_next        = cc_inc;
                                    if (cc_inc < cfg.carrier_high) begin
                                        pin_next = 1'b1;
                                    end else begin
                                        pin_next = 1'b0;
                                        if (cc_inc >= cfg.carrier_wrap) begin
                                            cc_next = '0;
                                        end
                                    end
                                end else begin
                                    cc_next         = '0;
                                    space_left_next = load_ptr;
                                    ptr_next        = ptr_reg + PTR_W'(1);
                                    in_mark_next    = 1'b0;
                                end
                            end else begin
                                cc_next = '0;
                                if (space_left_reg != '0) begin
                                    space_left_next = space_left_reg - DUR_W'(1);
                                    pin_next        = 1'b0;
                                end else begin
                                    in_mark_next   = 1'b1;
                                    mark_left_next = load_ptr;
                                    ptr_next       = ptr_reg + PTR_W'(1);
                                end
                            end
                        end else if (repeats_reg < cfg.repeat_count) begin
                            mark_left_next = load_zero;
                            ptr_next       = PTR_W'(1);
                            in_mark_next   = 1'b1;
                            repeats_next   = repeats_reg + CNT_W'(1);
                        end else begin
                            pin_next     = 1'b0;
                            running_next = 1'b0;
                            fin          = 1'b1;
                        end
                    end
                end
                OP_STOP: begin
                    running_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            in_mark_reg    <= 1'b1;
            mark_left_reg  <= '0;
            space_left_reg <= '0;
            cc_reg         <= '0;
            repeats_reg    <= '0;
            running_reg    <= 1'b0;
            pin_reg        <= 1'b0;
        end else begin
            ptr_reg        <= ptr_next;
            in_mark_reg    <= in_mark_next;
            mark_left_reg  <= mark_left_next;
            space_left_reg <= space_left_next;
            cc_reg         <= cc_next;
            repeats_reg    <= repeats_next;
            running_reg    <= running_next;
            pin_reg        <= pin_next;
        end
    end

    assign result.pin_level = pin_next;
    assign result.busy      = running_next;
    assign result.finished  = fin;

endmodule

### sv/ir_carrier_burst_transmitter_unit.sv
// Top level of the infrared carrier burst transmitter: handshakes, registers and result stage.
// The unit takes one item per clock cycle unless a held result waits on m_ready; each item is
// answered by one registered result item in the next cycle. The next duration is read from
// the table memory at the updated entry pointer, so it is ready on the tick that ends the current
// duration. No clearing pass is needed after reset; configuration writes are taken in every cycle.
module ir_carrier_burst_transmitter_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [irct_pkg::OP_W-1:0]        s_operation,
    input  logic [irct_pkg::IDX_W-1:0]       s_entry_index,
    input  logic [irct_pkg::DUR_W-1:0]       s_entry_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_pin_level,
    output logic                             m_busy_res,
    output logic                             m_finished,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [irct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irct_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import irct_pkg::*;

    cfg_t    cfg_reg;
    result_t res;
    result_t res_reg;
    logic    m_valid_reg;
    logic    accept;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seq_len      <= '0;
            cfg_reg.repeat_count <= CNT_W'(1);
            cfg_reg.carrier_high <= CNT_W'(8);
            cfg_reg.carrier_wrap <= CNT_W'(25);
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_SEQ_LEN:  cfg_reg.seq_len      <= cfg_data[SEQ_LEN_W-1:0];
                REG_REPEAT:   cfg_reg.repeat_count <= cfg_data[CNT_W-1:0];
                REG_CAR_HIGH: cfg_reg.carrier_high <= cfg_data[CNT_W-1:0];
                REG_CAR_WRAP: cfg_reg.carrier_wrap <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    irct_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .operation   (op_t'(s_operation)),
        .entry_index (s_entry_index),
        .entry_value (s_entry_value),
        .cfg         (cfg_reg),
        .result      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pin_level = res_reg.pin_level;
    assign m_busy_res  = res_reg.busy;
    assign m_finished  = res_reg.finished;

    a_fin_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> !m_busy_res)
        else $error("finished result reports a running transmission");

    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_START)) |=> (m_valid && m_busy_res && !m_pin_level))
        else $error("start did not give a running result with the pin low");

    a_stop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_STOP)) |=> (m_valid && !m_busy_res && !m_finished))
        else $error("stop did not end the transmission");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the result stage is empty");

endmodule
